// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the LZSS decoder.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property check on the rising clock edge, off while reset is held.
`define ASSERT_PROP(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Plain invariant, checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rstn, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(name, clk, rstn, expr, msg)
`endif

`endif

// File: rtl/xrl_pkg.sv
// Shared types and constants of the descrambling LZSS decoder.
// No dependencies; used by the controller, the datapath and the top level.
package xrl_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned LEN_W      = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE  = 2'd2;

  localparam logic [7:0]  SUB_CONST = 8'h7C;
  localparam int unsigned START_POS = 'h7DF;
  localparam logic [2:0]  ROT_RESET = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COPY
  } ctrl_state_e;

  // What the byte at the input would do if taken now
  typedef enum logic [2:0] {
    KIND_SKIP,
    KIND_FLAGS,
    KIND_LITERAL,
    KIND_LOW,
    KIND_HIGH
  } in_kind_e;

  typedef struct packed {
    logic take_in;   // input transaction completes this cycle
    logic copy_adv;  // one match byte goes to the output register
  } dp_cmd_t;

  typedef struct packed {
    in_kind_e kind;
    logic     out_free;   // output register can load this cycle
    logic     copy_last;  // current match byte ends the match or the output stream
  } dp_status_t;

endpackage

// File: rtl/xrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/xrl_dp.sv
// Datapath: config registers, descrambler, flag/match decode, history RAM,
// match copy pointers and output register. Uses xrl_pkg, xrl_ram, assert_macros.svh.
`include "assert_macros.svh"

module xrl_dp #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [xrl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [xrl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [7:0]                       in_byte_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [7:0]                       out_byte_o,
  output logic                             last_of_run_o,
  output logic                             stream_done_o,
  input  xrl_pkg::dp_cmd_t                 cmd_i,
  output xrl_pkg::dp_status_t              status_o
);

  import xrl_pkg::*;

  localparam int unsigned    AW        = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0]  StartPos  = AW'(START_POS);
  localparam logic [AW:0]    FullCount = (AW + 1)'(HISTORY_DEPTH);

  // Config
  logic [7:0]         xor_key_q;
  logic [2:0]         rot_shift_q;
  logic [COUNT_W-1:0] out_size_q;

  // Decoder state
  logic [8:0]         flag_q, flag_d;
  logic               await_q, await_d;
  logic [7:0]         low_q, low_d;
  logic [AW-1:0]      wp_q, wp_d;
  logic [AW:0]        fill_q, fill_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [LEN_W-1:0]   len_q, len_d;

  // Read tracking
  logic               byp_q, rvalid_q;
  logic [7:0]         byp_data_q;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q;
  logic               last_q, done_q;

  logic [7:0]         sub_byte, xor_byte, desc;
  logic [15:0]        rot_word;
  logic               stream_full, lit_emit, emit, copy_last, rd_hit, rd_written;
  logic [COUNT_W-1:0] cnt_inc;
  logic [7:0]         copy_byte, ram_rdata, wdata;
  logic [AW-1:0]      raddr, rd_off;
  in_kind_e           kind;

  // Descramble: subtract, XOR, rotate right
  always_comb begin
    sub_byte = in_byte_i - SUB_CONST;
    xor_byte = sub_byte ^ xor_key_q;
    rot_word = {xor_byte, xor_byte} >> rot_shift_q;
    desc     = rot_word[7:0];
  end

  always_comb begin
    stream_full = (count_q >= out_size_q);
    if (stream_full) begin
      kind = KIND_SKIP;
    end else if (await_q) begin
      kind = KIND_HIGH;
    end else if (flag_q <= 9'd1) begin
      kind = KIND_FLAGS;
    end else if (flag_q[0]) begin
      kind = KIND_LITERAL;
    end else begin
      kind = KIND_LOW;
    end
  end

  always_comb begin
    lit_emit   = cmd_i.take_in && (kind == KIND_LITERAL);
    emit       = lit_emit || cmd_i.copy_adv;
    cnt_inc    = count_q + COUNT_W'(1);
    copy_last  = (len_q == LEN_W'(1)) || (cnt_inc == out_size_q);
    copy_byte  = byp_q ? byp_data_q : (rvalid_q ? ram_rdata : 8'h00);
    wdata      = cmd_i.copy_adv ? copy_byte : desc;
    raddr      = cmd_i.copy_adv ? pos_q + AW'(1) : pos_q;
    // same-cycle write to the address being read: forward the new byte
    rd_hit     = emit && (raddr == wp_q);
    // written entries form a run from the start position, fill_q long
    rd_off     = raddr - StartPos;
    rd_written = ({1'b0, rd_off} < fill_q);
  end

  always_comb begin
    flag_d  = flag_q;
    await_d = await_q;
    low_d   = low_q;
    pos_d   = pos_q;
    len_d   = len_q;
    if (cmd_i.take_in) begin
      case (kind)
        KIND_FLAGS: begin
          flag_d = {1'b1, desc};
        end
        KIND_LITERAL: begin
          flag_d = flag_q >> 1;
        end
        KIND_LOW: begin
          low_d   = desc;
          await_d = 1'b1;
        end
        KIND_HIGH: begin
          await_d = 1'b0;
          flag_d  = flag_q >> 1;
          pos_d   = AW'({desc[7:5], low_q});
          len_d   = LEN_W'(desc[4:0]) + LEN_W'(2);
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.copy_adv) begin
      pos_d = pos_q + AW'(1);
      len_d = len_q - LEN_W'(1);
    end
    wp_d    = emit ? wp_q + AW'(1) : wp_q;
    count_d = emit ? cnt_inc : count_q;
    fill_d  = (emit && (fill_q != FullCount)) ? fill_q + (AW + 1)'(1) : fill_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_key_q   <= '0;
      rot_shift_q <= ROT_RESET;
      out_size_q  <= '0;
      flag_q      <= 9'd1;
      await_q     <= 1'b0;
      wp_q        <= StartPos;
      fill_q      <= '0;
      count_q     <= '0;
      byp_q       <= 1'b0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      low_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_XOR_KEY:   xor_key_q   <= cfg_data_i[7:0];
          CFG_ROT_SHIFT: rot_shift_q <= cfg_data_i[2:0];
          CFG_OUT_SIZE:  out_size_q  <= cfg_data_i[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      flag_q      <= flag_d;
      await_q     <= await_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      byp_q       <= rd_hit;
      rvalid_q    <= rd_written;
      out_valid_q <= out_valid_d;
      low_q       <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    len_q      <= len_d;
    byp_data_q <= wdata;
    if (emit) begin
      out_byte_q <= wdata;
      last_q     <= lit_emit ? 1'b1 : copy_last;
      done_q     <= (cnt_inc == out_size_q);
    end
  end

  xrl_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (emit),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.kind      = kind;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.copy_last = copy_last;

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign stream_done_o = done_q;

  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= FullCount, "fill count overflow")
  `ASSERT_PROP(a_copy_len, clk_i, rst_ni, cmd_i.copy_adv |-> len_q != '0, "copy past match end")
  `ASSERT_PROP(a_no_overwrite, clk_i, rst_ni, emit |-> (!out_valid_q || out_ready_i), "output lost")

endmodule

// File: rtl/xrl_ctrl.sv
// Controller FSM: input acceptance, match fetch and copy sequencing.
// Uses xrl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xrl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xrl_pkg::dp_status_t status_i,
  output xrl_pkg::dp_cmd_t    cmd_o
);

  import xrl_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.take_in  = 1'b0;
    cmd_o.copy_adv = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = status_i.out_free;
        cmd_o.take_in = in_valid_i && status_i.out_free;
        if (cmd_o.take_in && (status_i.kind == KIND_HIGH)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // first history read in flight
        state_d = ST_COPY;
      end
      ST_COPY: begin
        cmd_o.copy_adv = status_i.out_free;
        if (status_i.out_free && status_i.copy_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_PROP(a_fetch_copy, clk_i, rst_ni, state_q == ST_FETCH |=> state_q == ST_COPY, "fetch stuck")
  `ASSERT_PROP(a_high_fetch, clk_i, rst_ni, (cmd_o.take_in && status_i.kind == KIND_HIGH) |=> state_q == ST_FETCH, "match not started")
  `ASSERT_PROP(a_busy_block, clk_i, rst_ni, state_q != ST_IDLE |-> !in_ready_o, "input taken mid-match")

endmodule

// File: rtl/xor_rotate_lzss_decoder_top.sv
// Top level of the descrambling LZSS decoder with a 2 KB history window.
// Uses xrl_pkg, xrl_ctrl, xrl_dp (which holds xrl_ram).
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ---------------------   ------------------------------------------
//  cfg       in         cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//  in        in         in_valid_i/in_ready_o   in_byte_i
//  out       out        out_valid_o/out_ready_i out_byte_o, last_of_run_o, stream_done_o
//
// Sequencing: flag, literal and match low bytes are accepted in the idle state. A
// match high byte is accepted, the fetch state issues the first history read, then
// one match byte (2 to 33 in all) is copied per cycle while the output register is
// free; the single history read port and the one-byte output register set that rate.
// Reset: asynchronous, active low. The history needs no clearing pass; a fill
// count tracks the written run from the start position and unwritten entries
// read as zero, so the block takes input as soon as reset is released.
// Stalls: out_ready_i low holds the match copy; input is refused while the
// output register holds an untaken transaction or a match is being copied.
// Once out_size bytes are produced, further input transactions are taken and dropped.
module xor_rotate_lzss_decoder_top #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [xrl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [xrl_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      in_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            last_of_run_o,
  output logic                            stream_done_o
);

  import xrl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing: idle / fetch / copy
  xrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Descrambler, decoder state, history and output register
  xrl_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_byte_i     (in_byte_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
